// ===== rtl/core/modbus_response_checker_macros.svh =====
// assertion macros used by the checker rtl
`ifndef MODBUS_RESPONSE_CHECKER_MACROS_SVH
`define MODBUS_RESPONSE_CHECKER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("modbus response checker assertion failed");

// next-cycle implication, disabled while in reset
`define MRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("modbus response checker assertion failed");

`endif

// ===== rtl/core/mrc_pkg.sv =====
// shared types, codes and the crc-16 byte update for the modbus response checker
package mrc_pkg;

    localparam int MRC_MAX_FRAME_BYTES = 256;

    localparam logic [15:0] MRC_CRC_INIT = 16'hFFFF;
    localparam logic [15:0] MRC_CRC_POLY = 16'hA001;
    localparam logic [7:0]  MRC_EXC_BIT  = 8'h80;

    typedef logic [2:0] t_verdict;
    localparam t_verdict VERDICT_OK    = 3'd0;
    localparam t_verdict VERDICT_SHORT = 3'd1;
    localparam t_verdict VERDICT_EXC   = 3'd2;
    localparam t_verdict VERDICT_COUNT = 3'd3;
    localparam t_verdict VERDICT_CRC   = 3'd4;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index CFG_CHECK_MODE     = 1'b0;
    localparam t_cfg_index CFG_EXPECTED_COUNT = 1'b1;

    localparam int MRC_CFG_DATA_W = 7;
    localparam int MRC_COUNT_W    = 7;

    typedef struct packed {
        logic                   value_valid;
        logic signed [15:0]     reg_value;
        logic [MRC_COUNT_W-1:0] reg_index;
        logic                   verdict_valid;
        t_verdict               verdict;
    } t_step_result;

    // reflected crc-16, one byte, lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ MRC_CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/mrc_in_if.sv =====
// input byte channel
interface mrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// ===== rtl/core/mrc_out_if.sv =====
// result channel: register values and frame verdicts
interface mrc_out_if;
    logic               valid;
    logic               ready;
    logic               value_valid;
    logic signed [15:0] reg_value;
    logic [6:0]         reg_index;
    logic               verdict_valid;
    logic [2:0]         verdict;

    modport source (output valid, output value_valid, output reg_value, output reg_index,
                    output verdict_valid, output verdict, input ready);
    modport sink   (input valid, input value_valid, input reg_value, input reg_index,
                    input verdict_valid, input verdict, output ready);
endinterface

// ===== rtl/core/mrc_frame_core.sv =====
// frame state, running crc and per-byte decode of one response frame
module mrc_frame_core
    import mrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MRC_MAX_FRAME_BYTES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [7:0]             i_byte,
    input  logic                   i_end,
    input  logic                   i_check_mode,
    input  logic [MRC_COUNT_W-1:0] i_expected_count,
    output t_step_result           o_result
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (POS_W + 1 > 9) ? POS_W + 1 : 9;

    logic [15:0]      r_crc,   n_crc;
    logic [POS_W-1:0] r_pos,   n_pos;
    logic             r_exc,   n_exc;
    logic [7:0]       r_count, n_count;
    logic [7:0]       r_held,  n_held;
    logic             r_echo,  n_echo;

    logic             saturated;
    logic [CMP_W-1:0] idx;
    logic [CMP_W-1:0] len;
    logic [CMP_W-1:0] min_read_len;
    t_step_result     res;

    always_comb begin
        saturated    = (r_pos >= POS_W'(MAX_FRAME_BYTES));
        idx          = CMP_W'(r_pos - POS_W'(3)) >> 1;
        len          = CMP_W'(r_pos) + CMP_W'(1);
        min_read_len = CMP_W'(5) + CMP_W'({i_expected_count, 1'b0});

        n_crc   = crc16_byte(r_crc, i_byte);
        n_pos   = r_pos;
        n_exc   = r_exc;
        n_count = r_count;
        n_held  = r_held;
        n_echo  = r_echo;
        res     = '0;

        if (!saturated) begin
            if (r_pos == POS_W'(1) && (i_byte & MRC_EXC_BIT) != 8'h00) begin
                n_exc = 1'b1;
            end
            if (r_pos == POS_W'(2)) begin
                n_count = i_byte;
            end
            if (r_pos == POS_W'(7)) begin
                n_echo = (n_crc == 16'h0000);
            end
            if (i_check_mode == MODE_READ && r_pos >= POS_W'(3)) begin
                // data pairs start at byte 3, high byte at odd positions
                if (r_pos[0]) begin
                    n_held = i_byte;
                end else if (idx < CMP_W'(i_expected_count)) begin
                    res.value_valid = 1'b1;
                    res.reg_value   = {r_held, i_byte};
                    res.reg_index   = idx[MRC_COUNT_W-1:0];
                end
            end
            n_pos = r_pos + POS_W'(1);
        end

        if (i_end) begin
            res.verdict_valid = 1'b1;
            if (i_check_mode == MODE_READ) begin
                priority if (len < min_read_len)                      res.verdict = VERDICT_SHORT;
                else if (n_exc)                                       res.verdict = VERDICT_EXC;
                else if (n_count != {i_expected_count, 1'b0})         res.verdict = VERDICT_COUNT;
                else if (n_crc != 16'h0000)                           res.verdict = VERDICT_CRC;
                else                                                  res.verdict = VERDICT_OK;
            end else begin
                priority if (len < CMP_W'(8)) res.verdict = VERDICT_SHORT;
                else if (n_exc)               res.verdict = VERDICT_EXC;
                else if (!n_echo)             res.verdict = VERDICT_CRC;
                else                          res.verdict = VERDICT_OK;
            end
            // next frame starts clean
            n_crc   = MRC_CRC_INIT;
            n_pos   = '0;
            n_exc   = 1'b0;
            n_count = 8'h00;
            n_held  = 8'h00;
            n_echo  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= MRC_CRC_INIT;
            r_pos   <= '0;
            r_exc   <= 1'b0;
            r_count <= 8'h00;
            r_held  <= 8'h00;
            r_echo  <= 1'b0;
        end else if (i_fire) begin
            r_crc   <= n_crc;
            r_pos   <= n_pos;
            r_exc   <= n_exc;
            r_count <= n_count;
            r_held  <= n_held;
            r_echo  <= n_echo;
        end
    end

    assign o_result = res;

endmodule

// ===== rtl/core/modbus_response_checker.sv =====
// top level of the modbus rtu response checker
//
//  channel  dir  handshake        payload
//  i_in     in   valid / ready    rx_byte, frame_end
//  o_out    out  valid / ready    value_valid, reg_value, reg_index, verdict_valid, verdict
//  i_cfg_*  in   write enable     index 0 check_mode, index 1 expected_count
//
// one byte per cycle sustained unless a reporting byte meets a stalled result; a byte sits in the input register,
// is decoded with the running crc and is then registered into the result register.
// bytes that finish no register and end no frame leave no transaction on o_out.
// a stalled result holds the input register only when that byte must also report.
// synchronous active-low reset clears frame state and both valid flags and sets config to read mode, count 1.
module modbus_response_checker
    import mrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MRC_MAX_FRAME_BYTES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    mrc_in_if.sink                    i_in,
    mrc_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  t_cfg_index                i_cfg_index,
    input  logic [MRC_CFG_DATA_W-1:0] i_cfg_data
);

    logic                   r_check_mode;
    logic [MRC_COUNT_W-1:0] r_expected_count;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_end;

    logic                   r_out_valid;
    t_step_result           r_out;

    t_step_result           step;
    logic                   step_has;
    logic                   fire;

    assign step_has   = step.value_valid | step.verdict_valid;
    // a byte with nothing to report never waits on the result register
    assign fire       = r_in_valid & (!step_has | !r_out_valid | o_out.ready);
    assign i_in.ready = !r_in_valid | fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_mode     <= MODE_READ;
            r_expected_count <= MRC_COUNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHECK_MODE:     r_check_mode     <= i_cfg_data[0];
                CFG_EXPECTED_COUNT: r_expected_count <= i_cfg_data[MRC_COUNT_W-1:0];
                default:            r_check_mode     <= r_check_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.rx_byte;
            r_in_end  <= i_in.frame_end;
        end
    end

    mrc_frame_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_byte           (r_in_byte),
        .i_end            (r_in_end),
        .i_check_mode     (r_check_mode),
        .i_expected_count (r_expected_count),
        .o_result         (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && step_has) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && step_has) begin
            r_out <= step;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.value_valid   = r_out.value_valid;
    assign o_out.reg_value     = r_out.reg_value;
    assign o_out.reg_index     = r_out.reg_index;
    assign o_out.verdict_valid = r_out.verdict_valid;
    assign o_out.verdict       = r_out.verdict;

`include "modbus_response_checker_macros.svh"

    `MRC_ASSERT_NOW(a_out_has_content, i_clk, i_rst_n, r_out_valid, r_out.value_valid || r_out.verdict_valid)
    `MRC_ASSERT_NOW(a_verdict_code, i_clk, i_rst_n, r_out_valid && r_out.verdict_valid, r_out.verdict <= VERDICT_CRC)
    `MRC_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !i_in.ready, r_in_valid && step_has && r_out_valid && !o_out.ready)
    `MRC_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, i_in.valid && i_in.ready, r_in_valid)

endmodule

// ===== tb/sv/tb_modbus_response_checker.sv =====
// testbench for the modbus rtu response checker: register values, crc and frame verdicts
module tb_modbus_response_checker;
    import mrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_BYTES   = 300;
    localparam int QUIET_BYTES    = 100;
    localparam int LONG_HOLD      = 300;

    localparam logic [7:0] FN_READ_HOLDING = 8'h03;
    localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'h02;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we;
    t_cfg_index                i_cfg_index;
    logic [MRC_CFG_DATA_W-1:0] i_cfg_data;

    mrc_in_if  in_ch ();
    mrc_out_if out_ch ();

    modbus_response_checker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // predicted block state and configuration
    logic        mode_cfg;
    logic [6:0]  count_cfg;
    logic [15:0] crc_acc;
    logic [8:0]  frame_pos;
    logic        exc_flag;
    logic [7:0]  count_hold;
    logic [7:0]  high_hold;
    logic        echo_ok;

    t_step_result expected_results[$];
    logic [7:0]   frame_buf[$];

    int fail_count = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    int sink_stall_left = 0;
    int bytes_accepted = 0;
    bit idling_on = 1'b1;

    // crc-16/modbus fed one bit at a time, lsb first
    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c = {1'b0, c[15:1]};
            if (fb) begin
                c = c ^ MRC_CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void clear_frame();
        crc_acc    = MRC_CRC_INIT;
        frame_pos  = '0;
        exc_flag   = 1'b0;
        count_hold = '0;
        high_hold  = '0;
        echo_ok    = 1'b0;
    endfunction

    // advances the predicted state by one byte and queues the result it causes
    function automatic void model_byte(input logic [7:0] b, input logic fe);
        t_step_result r;
        int           pos;
        int           k;
        int           len;
        logic         sat;
        r = '0;
        pos = frame_pos;
        sat = (pos >= MRC_MAX_FRAME_BYTES);
        crc_acc = crc_next(crc_acc, b);
        if (!sat) begin
            if (pos == 1 && (b & MRC_EXC_BIT) != 0) begin
                exc_flag = 1'b1;
            end
            if (pos == 2) begin
                count_hold = b;
            end
            if (pos == 7) begin
                echo_ok = (crc_acc == 16'h0000);
            end
            if (mode_cfg == MODE_READ && pos >= 3) begin
                k = pos - 3;
                if (k % 2 == 0) begin
                    high_hold = b;
                end else if (k / 2 < count_cfg) begin
                    r.value_valid = 1'b1;
                    r.reg_value   = {high_hold, b};
                    r.reg_index   = 7'(k / 2);
                end
            end
            frame_pos = frame_pos + 1'b1;
        end
        if (fe) begin
            len = (sat ? MRC_MAX_FRAME_BYTES : pos) + 1;
            r.verdict_valid = 1'b1;
            if (mode_cfg == MODE_READ) begin
                if (len < 5 + 2 * count_cfg) begin
                    r.verdict = VERDICT_SHORT;
                end else if (exc_flag) begin
                    r.verdict = VERDICT_EXC;
                end else if (count_hold != 2 * count_cfg) begin
                    r.verdict = VERDICT_COUNT;
                end else if (crc_acc != 16'h0000) begin
                    r.verdict = VERDICT_CRC;
                end else begin
                    r.verdict = VERDICT_OK;
                end
            end else begin
                if (len < 8) begin
                    r.verdict = VERDICT_SHORT;
                end else if (exc_flag) begin
                    r.verdict = VERDICT_EXC;
                end else if (!echo_ok) begin
                    r.verdict = VERDICT_CRC;
                end else begin
                    r.verdict = VERDICT_OK;
                end
            end
            clear_frame();
        end
        if (r.value_valid || r.verdict_valid) begin
            expected_results.push_back(r);
        end
    endfunction

    // result sink: random stall bursts, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (sink_stall_left > 0) begin
            out_ch.ready <= 1'b0;
            sink_stall_left <= sink_stall_left - 1;
        end else if (idling_on && $urandom_range(0, 15) == 0) begin
            out_ch.ready <= 1'b0;
            sink_stall_left <= $urandom_range(0, 18);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_step_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result: value_valid=%0b value=%0d index=%0d",
                             out_ch.value_valid, out_ch.reg_value, out_ch.reg_index);
                    $display("                   verdict_valid=%0b verdict=%0d",
                             out_ch.verdict_valid, out_ch.verdict);
                end
            end else begin
                want = expected_results.pop_front();
                if (out_ch.value_valid !== want.value_valid || out_ch.reg_value !== want.reg_value
                        || out_ch.reg_index !== want.reg_index
                        || out_ch.verdict_valid !== want.verdict_valid
                        || out_ch.verdict !== want.verdict) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: expected vv=%0b value=%0d index=%0d dv=%0b verdict=%0d",
                                 want.value_valid, want.reg_value, want.reg_index,
                                 want.verdict_valid, want.verdict);
                        $display("          got      vv=%0b value=%0d index=%0d dv=%0b verdict=%0d",
                                 out_ch.value_valid, out_ch.reg_value, out_ch.reg_index,
                                 out_ch.verdict_valid, out_ch.verdict);
                    end
                end
            end
        end
    end

    // ends the run when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_modbus_response_checker: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fe);
        int gap;
        if (idling_on && $urandom_range(0, 11) == 0) begin
            gap = $urandom_range(1, 19);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.rx_byte   <= b;
        in_ch.frame_end <= fe;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        model_byte(b, fe);
        bytes_accepted++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++) begin
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
        frame_buf.delete();
    endtask

    // appends the crc of the frame built so far, low byte first
    function automatic void seal_crc();
        logic [15:0] c;
        c = MRC_CRC_INIT;
        foreach (frame_buf[i]) begin
            c = crc_next(c, frame_buf[i]);
        end
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endfunction

    function automatic void push_random(input int n);
        for (int i = 0; i < n; i++) begin
            frame_buf.push_back(8'($urandom));
        end
    endfunction

    // stops the sender and waits until the block has nothing left in flight
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_index idx, input logic [6:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == CFG_CHECK_MODE) begin
            mode_cfg = data[0];
        end else begin
            count_cfg = data;
        end
    endtask

    task automatic set_config(input logic mode, input logic [6:0] count);
        drain();
        write_cfg(CFG_CHECK_MODE, {6'b0, mode});
        write_cfg(CFG_EXPECTED_COUNT, count);
        i_cfg_we <= 1'b0;
    endtask

    // well-formed frame for the current mode; extra_regs skews read count or pads write echo
    function automatic void build_good_frame(input int extra_regs);
        int nregs;
        frame_buf.delete();
        frame_buf.push_back(8'($urandom));
        if (mode_cfg == MODE_READ) begin
            nregs = count_cfg + extra_regs;
            if (nregs < 0) begin
                nregs = 0;
            end
            frame_buf.push_back(FN_READ_HOLDING);
            frame_buf.push_back(8'(2 * nregs));
            push_random(2 * nregs);
            seal_crc();
        end else begin
            frame_buf.push_back(FN_WRITE_SINGLE);
            push_random(4);
            seal_crc();
            push_random(extra_regs > 0 ? extra_regs : 0);
        end
    endfunction

    task automatic test_read_response();
        set_config(MODE_READ, 7'd1);
        frame_buf = '{8'h11, FN_READ_HOLDING, 8'h02, 8'h80, 8'h00};
        seal_crc();
        send_frame();
        frame_buf = '{8'hF7, FN_READ_HOLDING, 8'h02, 8'h7F, 8'hFF};
        seal_crc();
        send_frame();
        // byte count disagrees with the configured register count
        frame_buf = '{8'h11, FN_READ_HOLDING, 8'h04, 8'h12, 8'h34, 8'h56, 8'h78};
        seal_crc();
        send_frame();
        frame_buf = '{8'h11, FN_READ_HOLDING, 8'h02, 8'hAB, 8'hCD};
        seal_crc();
        frame_buf[6] = frame_buf[6] ^ 8'h01;
        send_frame();
        frame_buf = '{8'h11, FN_READ_HOLDING, 8'h02, 8'hAB};
        send_frame();
        frame_buf = '{8'hFF};
        send_frame();
    endtask

    task automatic test_exception_reply();
        // with registers expected the short exception reply fails the length check first
        set_config(MODE_READ, 7'd1);
        frame_buf = '{8'h11, FN_READ_HOLDING | MRC_EXC_BIT, EXC_ILLEGAL_ADDR};
        seal_crc();
        send_frame();
        set_config(MODE_READ, 7'd0);
        frame_buf = '{8'h11, FN_READ_HOLDING | MRC_EXC_BIT, EXC_ILLEGAL_ADDR};
        seal_crc();
        send_frame();
        frame_buf = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00};
        send_frame();
    endtask

    task automatic test_write_echo();
        set_config(MODE_WRITE, 7'd3);
        frame_buf = '{8'h11, FN_WRITE_SINGLE, 8'h00, 8'h01, 8'hFF, 8'hFF};
        seal_crc();
        send_frame();
        // trailing bytes after the echo crc do not matter
        frame_buf = '{8'h22, FN_WRITE_SINGLE, 8'h80, 8'h00, 8'h00, 8'h00};
        seal_crc();
        push_random(3);
        send_frame();
        frame_buf = '{8'h22, FN_WRITE_SINGLE, 8'h00, 8'h10, 8'h12, 8'h34};
        seal_crc();
        frame_buf[7] = frame_buf[7] ^ 8'h80;
        send_frame();
        frame_buf = '{8'h22, FN_WRITE_SINGLE | MRC_EXC_BIT, EXC_ILLEGAL_ADDR};
        seal_crc();
        push_random(3);
        send_frame();
        frame_buf = '{8'h22, FN_WRITE_SINGLE, 8'h00, 8'h10, 8'h12, 8'h34, 8'h56};
        send_frame();
        frame_buf = '{8'h00};
        send_frame();
    endtask

    task automatic test_count_limits();
        set_config(MODE_READ, 7'd0);
        frame_buf = '{8'h01, FN_READ_HOLDING, 8'h00};
        seal_crc();
        send_frame();
        // data pairs beyond the configured count produce no values
        frame_buf = '{8'h01, FN_READ_HOLDING, 8'h04, 8'h01, 8'h02, 8'h03, 8'h04};
        seal_crc();
        send_frame();
    endtask

    task automatic test_overlong_frame();
        // position saturates; later bytes only feed the crc
        set_config(MODE_READ, 7'd125);
        frame_buf = '{8'h01, FN_READ_HOLDING, 8'd250};
        push_random(280);
        seal_crc();
        send_frame();
    endtask

    task automatic test_backpressure();
        set_config(MODE_READ, 7'd4);
        @(negedge i_clk);
        hold_left = LONG_HOLD;
        @(posedge i_clk);
        for (int i = 0; i < 6; i++) begin
            build_good_frame(0);
            send_frame();
        end
        drain();
        for (int i = 0; i < 3; i++) begin
            build_good_frame(0);
            send_frame();
        end
    endtask

    task automatic test_random_traffic();
        int start_bytes;
        int kind;
        int cut;
        int spot;
        start_bytes = bytes_accepted;
        while (bytes_accepted - start_bytes < RANDOM_BYTES) begin
            if (bytes_accepted - start_bytes >= RANDOM_BYTES - QUIET_BYTES) begin
                idling_on = 1'b0;
            end
            if ($urandom_range(0, 5) == 0) begin
                set_config(1'($urandom),
                           $urandom_range(0, 7) == 0 ? 7'($urandom_range(0, 125))
                                                     : 7'($urandom_range(0, 8)));
            end
            kind = $urandom_range(0, 9);
            if (kind <= 4) begin
                build_good_frame(0);
            end else if (kind == 5) begin
                build_good_frame($urandom_range(0, 1) ? $urandom_range(1, 3) : -1);
            end else if (kind == 6) begin
                frame_buf = '{8'($urandom), 8'($urandom) | MRC_EXC_BIT, 8'($urandom)};
                seal_crc();
                if (mode_cfg == MODE_WRITE) begin
                    push_random(3);
                end
            end else if (kind == 7) begin
                build_good_frame(0);
                spot = $urandom_range(0, frame_buf.size() - 1);
                frame_buf[spot] = frame_buf[spot] ^ (8'h01 << $urandom_range(0, 7));
            end else if (kind == 8) begin
                build_good_frame(0);
                cut = $urandom_range(1, frame_buf.size() - 1);
                while (frame_buf.size() > cut) void'(frame_buf.pop_back());
            end else begin
                frame_buf.delete();
                push_random($urandom_range(1, 12));
            end
            send_frame();
        end
    endtask

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.rx_byte   = '0;
        in_ch.frame_end = 1'b0;
        out_ch.ready    = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_CHECK_MODE;
        i_cfg_data      = '0;
        mode_cfg        = MODE_READ;
        count_cfg       = 7'd1;
        clear_frame();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_read_response();
        test_exception_reply();
        test_write_echo();
        test_count_limits();
        test_overlong_frame();
        test_backpressure();
        test_random_traffic();
        drain();

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("tb_modbus_response_checker: PASS");
        end else begin
            $display("tb_modbus_response_checker: FAIL");
        end
        $finish;
    end

endmodule
